// ===== rtl/fgrp_pkg.sv =====
// Shared constants for the Fibonacci-by-golden-ring-power block.
// No dependencies; imported by fgrp_ring_mul and the top level.
package fgrp_pkg;

  localparam int INDEX_BITS_DEF   = 7;
  localparam int VALUE_BITS_DEF   = 64;
  localparam int SIGNED_FIT_LIMIT = 92;

  // Partial products per full product (lo*lo, lo*hi, hi*lo) and products per ring multiply.
  localparam int PARTS_PER_PROD = 3;
  localparam int PRODS_PER_MUL  = 4;

  // Which of the four operand pairings a product uses.
  localparam logic [1:0] PROD_WW = 2'd0;  // x.whole * y.whole
  localparam logic [1:0] PROD_GG = 2'd1;  // x.gold  * y.gold
  localparam logic [1:0] PROD_WG = 2'd2;  // x.whole * y.gold
  localparam logic [1:0] PROD_GW = 2'd3;  // x.gold  * y.whole

  // Which halves a partial product uses.
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_LH = 2'd1;
  localparam logic [1:0] PART_HL = 2'd2;

  // Handshake between the sequencer and the ring multiplier.
  typedef struct packed {
    logic start;
  } rm_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rm_stat_t;

endpackage

// ===== rtl/fgrp_ring_mul.sv =====
// Ring multiply (a + b*phi)(c + d*phi) modulo 2^VALUE_BITS on one shared half-width multiplier.
// Depends on fgrp_pkg.
module fgrp_ring_mul
  import fgrp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rm_ctrl_t              ctrl,
  output rm_stat_t              stat,
  input  logic [VALUE_BITS-1:0] x_whole,
  input  logic [VALUE_BITS-1:0] x_gold,
  input  logic [VALUE_BITS-1:0] y_whole,
  input  logic [VALUE_BITS-1:0] y_gold,
  output logic [VALUE_BITS-1:0] res_whole,
  output logic [VALUE_BITS-1:0] res_gold
);

  localparam int H = (VALUE_BITS + 1) / 2;

  logic [VALUE_BITS-1:0] xw, xg, yw, yg;
  logic                  busy;
  logic                  done;
  logic [1:0]            p, q;
  logic                  last_issue;

  logic [VALUE_BITS-1:0] op_a, op_b;
  logic [H-1:0]          mul_a, mul_b;

  logic [2*H-1:0]        prod;
  logic                  prod_valid;
  logic                  prod_last;
  logic [1:0]            prod_p, prod_q;
  logic [VALUE_BITS-1:0] prod_v, term;

  logic [VALUE_BITS-1:0] acc_ww, acc_gg, acc_x;

  assign last_issue = (p == PROD_GW) && (q == PART_HL);

  always_comb begin
    op_a = ((p == PROD_WW) || (p == PROD_WG)) ? xw : xg;
    op_b = ((p == PROD_WW) || (p == PROD_GW)) ? yw : yg;
    mul_a = (q == PART_HL) ? H'(op_a >> H) : op_a[H-1:0];
    mul_b = (q == PART_LH) ? H'(op_b >> H) : op_b[H-1:0];
  end

  assign prod_v = VALUE_BITS'(prod);
  assign term   = (prod_q == PART_LL) ? prod_v : (prod_v << H);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      p          <= PROD_WW;
      q          <= PART_LL;
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
    end else begin
      done       <= prod_valid && prod_last;
      prod_valid <= busy;
      prod_last  <= busy && last_issue;
      if (ctrl.start) begin
        busy <= 1'b1;
        p    <= PROD_WW;
        q    <= PART_LL;
      end else if (busy) begin
        if (q == PART_HL) begin
          q <= PART_LL;
          p <= p + 2'd1;
        end else begin
          q <= q + 2'd1;
        end
        if (last_issue) busy <= 1'b0;
      end
    end
  end

  // Datapath: operand latch, product register, accumulators
  always_ff @(posedge clk) begin
    prod   <= (2*H)'(mul_a) * (2*H)'(mul_b);
    prod_p <= p;
    prod_q <= q;
    if (ctrl.start) begin
      xw     <= x_whole;
      xg     <= x_gold;
      yw     <= y_whole;
      yg     <= y_gold;
      acc_ww <= '0;
      acc_gg <= '0;
      acc_x  <= '0;
    end else if (prod_valid) begin
      unique case (prod_p)
        PROD_WW: acc_ww <= acc_ww + term;
        PROD_GG: acc_gg <= acc_gg + term;
        default: acc_x  <= acc_x + term;
      endcase
    end
  end

  assign res_whole = acc_ww + acc_gg;
  assign res_gold  = acc_x + acc_gg;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/fibonacci_by_golden_ring_power_top.sv =====
// Work per item: M = popcount(n) + bitlength(n) - 1 ring multiplies (none for n = 0).
// Flow: one item at a time; the next input beat is accepted only after the result register has
//   taken the last result, which waits while the result side stalls; each ring multiply issues
//   12 half-width partial products through fgrp_ring_mul.
// Reset: rst is synchronous, active high; clears the sequencer and the output valid.
// Depends on fgrp_pkg and fgrp_ring_mul.
module fibonacci_by_golden_ring_power_top
  import fgrp_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((INDEX_BITS+7)/8)*8-1:0]      s_tdata,   // [INDEX_BITS-1:0] index
  // Result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]      m_tdata,   // [VALUE_BITS-1:0] fib_value
  output logic                                 m_tuser    // [0] overflowed
);

  localparam int SW = 2;
  localparam logic [SW-1:0] ST_IDLE     = 2'd0;
  localparam logic [SW-1:0] ST_STEP     = 2'd1;  // pick next ring op or finish
  localparam logic [SW-1:0] ST_WAIT_ACC = 2'd2;  // acc <= acc * sq
  localparam logic [SW-1:0] ST_WAIT_SQ  = 2'd3;  // sq  <= sq * sq

  logic [SW-1:0]         state, state_next;
  logic [INDEX_BITS-1:0] e;         // remaining exponent bits
  logic                  ovf;
  logic [VALUE_BITS-1:0] acc_w, acc_g, sq_w, sq_g;
  logic [VALUE_BITS-1:0] fib_out;
  logic                  ovf_out;

  rm_ctrl_t              rm_ctrl;
  rm_stat_t              rm_stat;
  logic [VALUE_BITS-1:0] rm_whole, rm_gold;

  logic in_beat;
  logic out_free;
  logic finish;

  assign in_beat  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  // Result register is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;
  // All exponent bits consumed: acc holds phi^n, gold part is F(n).
  assign finish   = (state == ST_STEP) && (e == '0) && out_free;

  assign rm_ctrl.start = (state == ST_STEP) && (e != '0);

  // Shared ring multiplier; x is acc when the low exponent bit is set, else sq.
  fgrp_ring_mul #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ring_mul (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (rm_ctrl),
    .stat     (rm_stat),
    .x_whole  (e[0] ? acc_w : sq_w),
    .x_gold   (e[0] ? acc_g : sq_g),
    .y_whole  (sq_w),
    .y_gold   (sq_g),
    .res_whole(rm_whole),
    .res_gold (rm_gold)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_beat) state_next = ST_STEP;
      ST_STEP: begin
        if (e != '0) state_next = e[0] ? ST_WAIT_ACC : ST_WAIT_SQ;
        else if (out_free) state_next = ST_IDLE;
      end
      ST_WAIT_ACC: if (rm_stat.done) state_next = ST_STEP;
      ST_WAIT_SQ:  if (rm_stat.done) state_next = ST_STEP;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      e     <= s_tdata[INDEX_BITS-1:0];
      ovf   <= (32'(s_tdata[INDEX_BITS-1:0]) > 32'(SIGNED_FIT_LIMIT));
      acc_w <= VALUE_BITS'(1);
      acc_g <= '0;
      sq_w  <= '0;
      sq_g  <= VALUE_BITS'(1);
    end else if (rm_stat.done) begin
      if (state == ST_WAIT_ACC) begin
        acc_w <= rm_whole;
        acc_g <= rm_gold;
        e[0]  <= 1'b0;
      end else begin
        sq_w <= rm_whole;
        sq_g <= rm_gold;
        e    <= e >> 1;
      end
    end
    if (finish) begin
      fib_out <= acc_g;
      ovf_out <= ovf;
    end
  end

  assign m_tdata = ($bits(m_tdata))'(fib_out);
  assign m_tuser = ovf_out;

  // Checks
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rm_stat.done |-> (state == ST_WAIT_ACC || state == ST_WAIT_SQ))
    else $error("ring multiply finished outside a wait state");

  a_start_idle_mul: assert property (@(posedge clk) disable iff (rst)
    rm_ctrl.start |-> !rm_stat.busy)
    else $error("ring multiply started while busy");

  a_accept_to_step: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_STEP))
    else $error("accepted beat did not start the sequencer");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && e == '0 && !out_free) |=> (state == ST_STEP))
    else $error("result finished while output register still full");

endmodule
